### design/ttep_pkg.sv
// ----------------------------------------------------------------------------
// ttep_pkg
// Shared types and constants for the text terminal escape parser: screen
// geometry, byte codes, parser modes and control states.
// ----------------------------------------------------------------------------
package ttep_pkg;

  // Screen geometry and control sequence limit
  localparam int ROWS         = 24;
  localparam int COLS         = 80;
  localparam int SEQ_BUF_SIZE = 32;

  localparam int CELL_COUNT = ROWS * COLS;
  localparam int CELL_AW    = $clog2(CELL_COUNT);
  localparam int SEQ_W      = $clog2(SEQ_BUF_SIZE);

  // Field widths
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 7;

  // Byte codes
  localparam logic [7:0] CHAR_BS     = 8'h08;
  localparam logic [7:0] CHAR_LF     = 8'h0a;
  localparam logic [7:0] CHAR_CR     = 8'h0d;
  localparam logic [7:0] CHAR_ESC    = 8'h1b;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_DEL    = 8'h7f;
  localparam logic [7:0] CHAR_AT     = 8'h40;
  localparam logic [7:0] CHAR_TILDE  = 8'h7e;
  localparam logic [7:0] CHAR_LBRACK = 8'h5b;
  localparam logic [7:0] CHAR_J      = 8'h4a;
  localparam logic [7:0] CHAR_K      = 8'h4b;

  // Item opcodes
  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Parser modes, as reported on parser_mode
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_SEQ    = 2'd2
  } parser_mode_e;

  // Control states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_READ  = 2'd1,
    ST_CLEAR = 2'd2
  } ctrl_state_e;

endpackage

### design/text_terminal_escape_parser.sv
// ----------------------------------------------------------------------------
// text_terminal_escape_parser
// Text-screen terminal with a normal / escape / control sequence parser and
// a screen of ROWS x COLS cells held in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per transfer:
//   opcode 0 feeds data_byte to the parser, opcode 1 reads the cell at
//   read_row / read_col. Every item produces exactly one result on the
//   output channel (out_valid_o / out_stall_i): the cell character for a
//   read (0 for a feed or an out-of-range cell), plus the cursor position
//   and parser mode after the item.
//   A feed result is registered at the transfer edge; a read waits in the
//   read state for the registered cell memory port before its result is
//   registered. Throughput: one feed per cycle while the output is not
//   stalled; a read holds off the next item until its result is registered.
//   An erase ('J' final byte) walks all 1920 cells at one write per cycle,
//   and an erase-to-end-of-row ('K') walks the rest of the row; no item is
//   taken during the walk, as the cell memory has a single write port.
//   Reset: cursor homes, parser returns to normal mode and the screen is
//   filled with spaces by a pass over all 1920 cells, with in_stall_o held high.
//   A stalled result holds in the output register; a new item is taken
//   only once that register is free or being emptied in the same cycle.
// ----------------------------------------------------------------------------
module text_terminal_escape_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       opcode_i,
  input  logic [7:0]                 data_byte_i,
  input  logic [ttep_pkg::ROW_W-1:0] read_row_i,
  input  logic [ttep_pkg::COL_W-1:0] read_col_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ttep_pkg::CHAR_W-1:0] read_char_o,
  output logic [ttep_pkg::ROW_W-1:0]  cursor_row_o,
  output logic [ttep_pkg::COL_W-1:0]  cursor_col_o,
  output logic [1:0]                  parser_mode_o
);

  localparam int AW = ttep_pkg::CELL_AW;

  // Cell memory
  logic [ttep_pkg::CHAR_W-1:0] mem [ttep_pkg::CELL_COUNT];
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [ttep_pkg::CHAR_W-1:0] mem_wdata;
  logic [AW-1:0]               rd_addr;
  logic [ttep_pkg::CHAR_W-1:0] rd_data_q;

  // Control and cursor state
  ttep_pkg::ctrl_state_e       state_q, state_d;
  ttep_pkg::parser_mode_e      mode_q, mode_d;
  logic [ttep_pkg::ROW_W-1:0]  row_q, row_d;
  logic [ttep_pkg::COL_W-1:0]  col_q, col_d;
  logic [ttep_pkg::SEQ_W-1:0]  seq_len_q, seq_len_d;
  logic [AW-1:0]               clr_ptr_q, clr_ptr_d;
  logic [AW-1:0]               clr_end_q, clr_end_d;
  logic                        rd_ok_q, rd_ok_d;

  // Output register
  logic                        out_valid_q, out_valid_d;
  logic [ttep_pkg::CHAR_W-1:0] out_char_q, out_char_d;
  logic [ttep_pkg::ROW_W-1:0]  out_row_q, out_row_d;
  logic [ttep_pkg::COL_W-1:0]  out_col_q, out_col_d;
  logic [1:0]                  out_mode_q, out_mode_d;

  // Handshake and feed decode
  logic          accept;
  logic          out_free;
  logic          is_feed;
  logic          feed_we;
  logic          clr_start;
  logic [AW-1:0] clr_from;
  logic [AW-1:0] clr_to;
  logic [AW-1:0] row_base;
  logic [AW-1:0] cur_addr;
  logic          rd_in_range;
  logic          seq_done;
  logic [ttep_pkg::ROW_W:0] row_inc;

  assign out_free   = !out_valid_q || !out_stall_i;
  // Take an item only in idle and only with room in the output register
  assign in_stall_o = (state_q != ttep_pkg::ST_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_feed    = (opcode_i == ttep_pkg::OP_FEED);

  // Cell addresses for the cursor and for a read request
  assign row_base = AW'(row_q) * AW'(ttep_pkg::COLS);
  assign cur_addr = row_base + AW'(col_q);
  assign rd_in_range = (read_row_i < ttep_pkg::ROW_W'(ttep_pkg::ROWS)) &&
                       (read_col_i < ttep_pkg::COL_W'(ttep_pkg::COLS));
  assign rd_addr  = rd_in_range
                  ? AW'(read_row_i) * AW'(ttep_pkg::COLS) + AW'(read_col_i)
                  : '0;
  assign row_inc  = {1'b0, row_q} + 1'b1;
  assign seq_done = ((data_byte_i >= ttep_pkg::CHAR_AT) &&
                     (data_byte_i <= ttep_pkg::CHAR_TILDE)) ||
                    (seq_len_q >= ttep_pkg::SEQ_W'(ttep_pkg::SEQ_BUF_SIZE - 1));

  // Parser: next cursor, mode and any cell write or clear for a fed byte
  always_comb begin
    mode_d    = mode_q;
    row_d     = row_q;
    col_d     = col_q;
    seq_len_d = seq_len_q;
    feed_we   = 1'b0;
    clr_start = 1'b0;
    clr_from  = '0;
    clr_to    = AW'(ttep_pkg::CELL_COUNT - 1);
    case (mode_q)
      ttep_pkg::MODE_NORMAL: begin
        if (data_byte_i == ttep_pkg::CHAR_ESC) begin
          mode_d = ttep_pkg::MODE_ESC;
        end else if (data_byte_i == ttep_pkg::CHAR_CR) begin
          col_d = '0;
        end else if (data_byte_i == ttep_pkg::CHAR_LF) begin
          if (row_inc < (ttep_pkg::ROW_W + 1)'(ttep_pkg::ROWS)) begin
            row_d = row_inc[ttep_pkg::ROW_W-1:0];
          end
          col_d = '0;
        end else if (data_byte_i == ttep_pkg::CHAR_BS) begin
          if (col_q != '0) begin
            col_d = col_q - 1'b1;
          end
        end else if ((data_byte_i >= ttep_pkg::CHAR_SPACE) &&
                     (data_byte_i < ttep_pkg::CHAR_DEL)) begin
          // drop the byte when the cursor sits past the last column
          if ((row_q < ttep_pkg::ROW_W'(ttep_pkg::ROWS)) &&
              (col_q < ttep_pkg::COL_W'(ttep_pkg::COLS))) begin
            feed_we = 1'b1;
            col_d   = col_q + 1'b1;
          end
        end
      end
      ttep_pkg::MODE_ESC: begin
        if (data_byte_i == ttep_pkg::CHAR_LBRACK) begin
          mode_d    = ttep_pkg::MODE_SEQ;
          seq_len_d = '0;
        end else begin
          mode_d = ttep_pkg::MODE_NORMAL;
        end
      end
      ttep_pkg::MODE_SEQ: begin
        if (seq_done) begin
          if (data_byte_i == ttep_pkg::CHAR_J) begin
            clr_start = 1'b1;
            row_d     = '0;
            col_d     = '0;
          end else if (data_byte_i == ttep_pkg::CHAR_K) begin
            // erase to end of row; nothing to do past the last column
            if ((row_q < ttep_pkg::ROW_W'(ttep_pkg::ROWS)) &&
                (col_q < ttep_pkg::COL_W'(ttep_pkg::COLS))) begin
              clr_start = 1'b1;
              clr_from  = cur_addr;
              clr_to    = row_base + AW'(ttep_pkg::COLS - 1);
            end
          end
          mode_d = ttep_pkg::MODE_NORMAL;
        end else begin
          seq_len_d = seq_len_q + 1'b1;
        end
      end
      default: begin
        mode_d = ttep_pkg::MODE_NORMAL;
      end
    endcase
  end

  // Next control state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ttep_pkg::ST_IDLE: begin
        if (accept) begin
          if (!is_feed) begin
            state_d = ttep_pkg::ST_READ;
          end else if (clr_start) begin
            state_d = ttep_pkg::ST_CLEAR;
          end
        end
      end
      ttep_pkg::ST_READ: begin
        state_d = ttep_pkg::ST_IDLE;
      end
      ttep_pkg::ST_CLEAR: begin
        if (clr_ptr_q == clr_end_q) begin
          state_d = ttep_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ttep_pkg::ST_IDLE;
      end
    endcase
  end

  // Control outputs: memory write port, clear pointers and result updates
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = cur_addr;
    mem_wdata  = data_byte_i[ttep_pkg::CHAR_W-1:0];
    clr_ptr_d  = clr_ptr_q;
    clr_end_d  = clr_end_q;
    rd_ok_d    = rd_ok_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_char_d  = out_char_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_mode_d  = out_mode_q;
    case (state_q)
      ttep_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_feed) begin
            mem_we      = feed_we;
            clr_ptr_d   = clr_from;
            clr_end_d   = clr_to;
            out_valid_d = 1'b1;
            out_char_d  = '0;
            out_row_d   = row_d;
            out_col_d   = col_d;
            out_mode_d  = mode_d;
          end else begin
            rd_ok_d = rd_in_range;
          end
        end
      end
      ttep_pkg::ST_READ: begin
        // output register is free here: it was free at the transfer edge
        out_valid_d = 1'b1;
        out_char_d  = rd_ok_q ? rd_data_q : '0;
        out_row_d   = row_q;
        out_col_d   = col_q;
        out_mode_d  = mode_q;
      end
      ttep_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_ptr_q;
        mem_wdata = ttep_pkg::CHAR_SPACE[ttep_pkg::CHAR_W-1:0];
        clr_ptr_d = clr_ptr_q + 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Cell memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[rd_addr];
  end

  // Control registers; reset starts the screen clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ttep_pkg::ST_CLEAR;
      mode_q      <= ttep_pkg::MODE_NORMAL;
      row_q       <= '0;
      col_q       <= '0;
      seq_len_q   <= '0;
      clr_ptr_q   <= '0;
      clr_end_q   <= AW'(ttep_pkg::CELL_COUNT - 1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_ptr_q   <= clr_ptr_d;
      clr_end_q   <= clr_end_d;
      out_valid_q <= out_valid_d;
      if (accept && is_feed) begin
        mode_q    <= mode_d;
        row_q     <= row_d;
        col_q     <= col_d;
        seq_len_q <= seq_len_d;
      end
    end
  end

  // Result payload and read bookkeeping
  always_ff @(posedge clk_i) begin
    rd_ok_q    <= rd_ok_d;
    out_char_q <= out_char_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_mode_q <= out_mode_d;
  end

  assign out_valid_o   = out_valid_q;
  assign read_char_o   = out_char_q;
  assign cursor_row_o  = out_row_q;
  assign cursor_col_o  = out_col_q;
  assign parser_mode_o = out_mode_q;

endmodule

### tb/ttep_screen_checker.sv
// ----------------------------------------------------------------------------
// ttep_screen_checker
// Watches both channels of the text terminal escape parser. It keeps its own
// copy of the screen, cursor and parser mode, works out the result of each
// input transfer and compares every output transfer, field by field, with
// the oldest outstanding result.
// ----------------------------------------------------------------------------
module ttep_screen_checker
  import ttep_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // input channel, observed
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              opcode_i,
  input  logic [7:0]        data_byte_i,
  input  logic [ROW_W-1:0]  read_row_i,
  input  logic [COL_W-1:0]  read_col_i,
  // output channel, observed
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [CHAR_W-1:0] read_char_i,
  input  logic [ROW_W-1:0]  cursor_row_i,
  input  logic [COL_W-1:0]  cursor_col_i,
  input  logic [1:0]        parser_mode_i,
  // status for the testbench top
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_CAP = 60;

  typedef struct packed {
    logic [CHAR_W-1:0] read_char;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    parser_mode_e      mode;
  } term_view_t;

  // Predicted terminal state
  logic [CHAR_W-1:0] cells [ROWS][COLS];
  int unsigned       cur_row;
  int unsigned       cur_col;
  int unsigned       seq_len;
  parser_mode_e      mode_q;

  term_view_t        expected_views [$];
  term_view_t        next_view;
  term_view_t        want;
  int unsigned       reported;

  // Fill every cell with a space
  function automatic void blank_screen();
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        cells[r][c] = CHAR_SPACE[CHAR_W-1:0];
      end
    end
  endfunction

  // Flag one field that differs from its prediction
  function automatic void check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
    if (act_val !== exp_val) begin
      fail_count_o++;
      if (reported < REPORT_CAP) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                 act_val);
      end
      reported++;
    end
  endfunction

  // Advance the predicted terminal by one item and return its result
  task automatic apply_terminal_item(input logic op, input logic [7:0] b,
                                     input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc,
                                     output term_view_t view);
    logic [CHAR_W-1:0] ch;
    ch = '0;
    if (op == OP_READ) begin
      if (rr < ROWS && rc < COLS) ch = cells[rr][rc];
    end else begin
      case (mode_q)
        MODE_NORMAL: begin
          if (b == CHAR_ESC) begin
            mode_q = MODE_ESC;
          end else if (b == CHAR_CR) begin
            cur_col = 0;
          end else if (b == CHAR_LF) begin
            // no scroll: stay on the last row
            if (cur_row + 1 < ROWS) cur_row++;
            cur_col = 0;
          end else if (b == CHAR_BS) begin
            if (cur_col > 0) cur_col--;
          end else if (b >= CHAR_SPACE && b < CHAR_DEL) begin
            // drop the byte when the cursor sits past the last column
            if (cur_col < COLS) begin
              cells[cur_row][cur_col] = b[CHAR_W-1:0];
              cur_col++;
            end
          end
        end
        MODE_ESC: begin
          if (b == CHAR_LBRACK) begin
            mode_q  = MODE_SEQ;
            seq_len = 0;
          end else begin
            mode_q = MODE_NORMAL;
          end
        end
        default: begin
          // a final byte or a full buffer ends the sequence
          if ((b >= CHAR_AT && b <= CHAR_TILDE) || seq_len >= SEQ_BUF_SIZE - 1) begin
            if (b == CHAR_J) begin
              blank_screen();
              cur_row = 0;
              cur_col = 0;
            end else if (b == CHAR_K) begin
              for (int k = cur_col; k < COLS; k++) cells[cur_row][k] = CHAR_SPACE[CHAR_W-1:0];
            end
            mode_q = MODE_NORMAL;
          end else begin
            seq_len++;
          end
        end
      endcase
    end
    view.read_char = ch;
    view.row       = cur_row[ROW_W-1:0];
    view.col       = cur_col[COL_W-1:0];
    view.mode      = mode_q;
  endtask

  // Compare output transfers, then record input transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_screen();
      cur_row = 0;
      cur_col = 0;
      seq_len = 0;
      mode_q  = MODE_NORMAL;
      expected_views.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      reported     = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_views.size() == 0) begin
          fail_count_o++;
          $display("%0t ns: result with no transfer outstanding, expected none, actual char %0d row %0d col %0d mode %0d",
                   $time, read_char_i, cursor_row_i, cursor_col_i, parser_mode_i);
        end else begin
          want = expected_views.pop_front();
          checked_o++;
          check_field("read_char", 8'(want.read_char), 8'(read_char_i));
          check_field("cursor_row", 8'(want.row), 8'(cursor_row_i));
          check_field("cursor_col", 8'(want.col), 8'(cursor_col_i));
          check_field("parser_mode", 8'(want.mode), 8'(parser_mode_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_terminal_item(opcode_i, data_byte_i, read_row_i, read_col_i, next_view);
        expected_views.push_back(next_view);
      end
      pending_o = expected_views.size();
    end
  end

endmodule

### tb/tb_text_terminal_escape_parser.sv
// ----------------------------------------------------------------------------
// tb_text_terminal_escape_parser
// Drives the text terminal with a directed opening (field extremes, control
// bytes, escape handling, erases) and then with random text, cursor moves,
// control sequences, overlong sequences, broken escapes, noise and cell
// reads, under random sender gaps and receiver stalls. A separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_text_terminal_escape_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import ttep_pkg::*;

  localparam int unsigned ITEM_TARGET = 1550;
  localparam int unsigned QUIET_LIMIT = 10000;
  localparam int unsigned PAUSE_EVERY = 400;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic              opcode     = OP_FEED;
  logic [7:0]        data_byte  = '0;
  logic [ROW_W-1:0]  read_row   = '0;
  logic [COL_W-1:0]  read_col   = '0;
  logic              out_stall  = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [CHAR_W-1:0] read_char;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;
  logic [1:0]        parser_mode;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  // Stimulus bookkeeping
  int unsigned items_sent   = 0;
  int unsigned reads_sent   = 0;
  int unsigned clears_sent  = 0;
  int unsigned erases_sent  = 0;
  int unsigned long_seqs    = 0;
  int unsigned burst_left   = 0;
  int unsigned gap_max      = 0;
  int unsigned next_pause   = PAUSE_EVERY;
  int unsigned quiet_cycles = 0;
  int unsigned stall_phase  = 0;
  logic [1:0]  stall_style  = 2'd0;

  text_terminal_escape_parser uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .opcode_i      (opcode),
    .data_byte_i   (data_byte),
    .read_row_i    (read_row),
    .read_col_i    (read_col),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .read_char_o   (read_char),
    .cursor_row_o  (cursor_row),
    .cursor_col_o  (cursor_col),
    .parser_mode_o (parser_mode)
  );

  ttep_screen_checker u_screen_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .opcode_i      (opcode),
    .data_byte_i   (data_byte),
    .read_row_i    (read_row),
    .read_col_i    (read_col),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .read_char_i   (read_char),
    .cursor_row_i  (cursor_row),
    .cursor_col_i  (cursor_col),
    .parser_mode_i (parser_mode),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Switch the receiver's stall style after a random wait
  initial begin
    forever begin
      @(posedge clk);
      stall_style = 2'($urandom_range(0, 3));
      repeat ($urandom_range(50, 400)) @(posedge clk);
    end
  end

  // Drive the output stall: none, light random, periodic, heavy random
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    case (stall_style)
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 99) < 35);
      2'd2:    out_stall <= ((stall_phase % 7) < 3);
      default: out_stall <= ($urandom_range(0, 99) < 85);
    endcase
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, pending);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Send one item, inserting a random gap at the start of each burst
  task automatic drive_transfer(input logic op, input logic [7:0] b,
                                input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid  <= 1'b1;
    opcode    <= op;
    data_byte <= b;
    read_row  <= rr;
    read_col  <= rc;
    // hold until the transfer
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic feed(input logic [7:0] b);
    drive_transfer(OP_FEED, b, ROW_W'($urandom), COL_W'($urandom));
  endtask

  task automatic read_cell(input int unsigned r, input int unsigned c);
    reads_sent++;
    drive_transfer(OP_READ, 8'($urandom), r[ROW_W-1:0], c[COL_W-1:0]);
  endtask

  // Mostly on-screen cells, sometimes anywhere in the field range
  task automatic read_random_cell();
    if ($urandom_range(0, 99) < 85) read_cell($urandom_range(0, ROWS - 1),
                                              $urandom_range(0, COLS - 1));
    else read_cell($urandom_range(0, 31), $urandom_range(0, 127));
  endtask

  // Stop the sender until every outstanding result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
  endtask

  // A byte that does not end a control sequence
  function automatic logic [7:0] seq_filler();
    logic [7:0] b;
    if ($urandom_range(0, 99) < 70) return 8'($urandom_range(8'h30, 8'h3b));
    do b = 8'($urandom_range(0, 255)); while (b >= CHAR_AT && b <= CHAR_TILDE);
    return b;
  endfunction

  // ESC '[' with parameter bytes, a terminator, and reads mixed in
  task automatic send_control_seq(input logic [7:0] term, input int unsigned nparams);
    feed(CHAR_ESC);
    feed(CHAR_LBRACK);
    for (int i = 0; i < nparams; i++) begin
      if ($urandom_range(0, 99) < 10) read_random_cell();
      feed(seq_filler());
    end
    if (term == CHAR_J) clears_sent++;
    if (term == CHAR_K) erases_sent++;
    feed(term);
  endtask

  // One random stimulus step
  task automatic random_step();
    int unsigned kind;
    int unsigned len;
    logic [7:0]  b;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      read_random_cell();
    end else if (kind < 47) begin
      len = $urandom_range(1, 12);
      repeat (len) feed(8'($urandom_range(32, 126)));
    end else if (kind < 55) begin
      case ($urandom_range(0, 3))
        0: feed(CHAR_CR);
        1: feed(CHAR_LF);
        2: feed(CHAR_BS);
        default: begin
          feed(CHAR_CR);
          feed(CHAR_LF);
        end
      endcase
    end else if (kind < 60) begin
      // run a line past the last column, often erase from there
      feed(CHAR_CR);
      len = $urandom_range(70, 90);
      repeat (len) feed(8'($urandom_range(32, 126)));
      if ($urandom_range(0, 1) == 1) send_control_seq(CHAR_K, $urandom_range(0, 2));
    end else if (kind < 64) begin
      len = $urandom_range(5, 30);
      repeat (len) feed(CHAR_LF);
    end else if (kind < 75) begin
      send_control_seq(CHAR_K, $urandom_range(0, 4));
    end else if (kind < 77) begin
      send_control_seq(CHAR_J, $urandom_range(0, 4));
    end else if (kind < 83) begin
      send_control_seq(8'($urandom_range(CHAR_AT, CHAR_TILDE)), $urandom_range(0, 4));
    end else if (kind < 86) begin
      // long sequence near or past the buffer limit, which ends it when reached
      long_seqs++;
      case ($urandom_range(0, 3))
        0:       b = CHAR_J;
        1:       b = CHAR_K;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_control_seq(b, $urandom_range(SEQ_BUF_SIZE - 3, SEQ_BUF_SIZE + 2));
    end else if (kind < 92) begin
      // escape followed by something other than '['
      feed(CHAR_ESC);
      feed(8'($urandom_range(0, 255)));
    end else begin
      feed(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening: reads at the edges, control bytes, escapes, erases
    gap_max = 0;
    read_cell(0, 0);
    read_cell(31, 127);
    read_cell(ROWS, 0);
    read_cell(0, COLS);
    feed(CHAR_SPACE);
    feed(CHAR_TILDE);
    feed(CHAR_DEL);
    feed(8'hff);
    feed(8'h00);
    feed(CHAR_BS);
    feed(CHAR_CR);
    feed(CHAR_BS);
    feed(CHAR_LF);
    read_cell(0, 1);
    feed(CHAR_ESC);
    feed(8'h78);
    send_control_seq(CHAR_K, 1);
    read_cell(ROWS - 1, COLS - 1);
    send_control_seq(CHAR_J, 0);
    read_cell(0, 1);
    wait_drained();

    // Random part, pausing now and then until every result is back
    gap_max = 3;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_pause) begin
        wait_drained();
        case ($urandom_range(0, 3))
          0:       gap_max = 0;
          1:       gap_max = 1;
          2:       gap_max = 3;
          default: gap_max = 8;
        endcase
        next_pause = items_sent + PAUSE_EVERY;
      end
      random_step();
    end

    wait_drained();
    repeat (20) @(posedge clk);

    $display("Sent %0d items: %0d cell reads, %0d screen erases, %0d line erases, %0d overlong sequences.",
             items_sent, reads_sent, clears_sent, erases_sent, long_seqs);
    $display("Checked %0d results against the predicted screen, cursor and parser mode.",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
